// ===== design/segment_squared_loss_accumulator_defines.svh =====
// Assertion macros for the segment squared-loss accumulator.
// Included by the top level; no other dependencies.
`ifndef SEGMENT_SQUARED_LOSS_ACCUMULATOR_DEFINES_SVH
`define SEGMENT_SQUARED_LOSS_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SSLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssla assertion failed");
`define SSLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssla assertion failed");
`else
`define SSLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SSLA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ssla_pkg.sv =====
// Shared types and constants of the segment squared-loss accumulator.
// No dependencies.
`default_nettype none
package ssla_pkg;
    localparam int COUNT_W     = 16;
    localparam int SUM_W       = 32;
    localparam int SQ_W        = 48;
    localparam int VALUE_W     = 16;
    localparam int IDX_W       = 4;
    localparam int OP_W        = 2;
    localparam int OBJ_W       = 49;
    localparam int SAMPLES_W   = 5;
    localparam int PENALTY_W   = 31;
    localparam int BASE_W      = 47;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 47;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [OBJ_W-1:0]   OBJ_MAX   = '1;

    // input op codes
    localparam logic [OP_W-1:0] OP_ACC  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLR  = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOLED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd3;

    typedef enum logic [1:0] {CMD_ACC, CMD_CLR, CMD_EVAL} t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                  kind;
        logic [IDX_W-1:0]           idx;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic signed [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]          sumsq;
    } t_slot;
endpackage
`default_nettype wire

// ===== design/ssla_in_if.sv =====
// Input channel of the accumulator: valid, ready and one input word.
// Depends on ssla_pkg.
`default_nettype none
interface ssla_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [ssla_pkg::OP_W-1:0]             op;
    logic [ssla_pkg::IDX_W-1:0]            sample_index;
    logic signed [ssla_pkg::VALUE_W-1:0]   value;
    logic                                  is_missing;

    modport source(output valid, output op, output sample_index, output value,
                   output is_missing, input ready);
    modport sink(input valid, input op, input sample_index, input value,
                 input is_missing, output ready);
endinterface
`default_nettype wire

// ===== design/ssla_out_if.sv =====
// Result channel of the accumulator: valid, ready and the objective.
// Depends on ssla_pkg.
`default_nettype none
interface ssla_out_if;
    logic                           valid;
    logic                           ready;
    logic [ssla_pkg::OBJ_W-1:0]     objective;

    modport source(output valid, output objective, input ready);
    modport sink(input valid, input objective, output ready);
endinterface
`default_nettype wire

// ===== design/ssla_front.sv =====
// Front end: accepts input words, drops those with no effect, forms commands.
// Depends on ssla_pkg and ssla_in_if.
`default_nettype none
module ssla_front #(
    parameter int MAX_SAMPLES = 16,
    localparam int UW = $clog2(MAX_SAMPLES + 1)
) (
    ssla_in_if.sink             i_in,
    input  logic [UW-1:0]       i_slots,
    input  ssla_pkg::t_q_stat   i_q_stat,
    output logic                o_push,
    output ssla_pkg::t_cmd      o_cmd
);
    logic keep;

    // take a word whenever the queue has room
    assign i_in.ready = !i_q_stat.full;

    // classify the word; drop missing values, out-of-range slots and unused codes
    always_comb begin
        o_cmd.idx   = i_in.sample_index;
        o_cmd.value = i_in.value;
        o_cmd.kind  = ssla_pkg::CMD_EVAL;
        keep        = 1'b0;
        unique case (i_in.op)
            ssla_pkg::OP_ACC: begin
                o_cmd.kind = ssla_pkg::CMD_ACC;
                keep = !i_in.is_missing && (32'(i_in.sample_index) < 32'(i_slots));
            end
            ssla_pkg::OP_CLR: begin
                o_cmd.kind = ssla_pkg::CMD_CLR;
                keep = 1'b1;
            end
            ssla_pkg::OP_EVAL: begin
                o_cmd.kind = ssla_pkg::CMD_EVAL;
                keep = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_push = i_in.valid && i_in.ready && keep;
endmodule
`default_nettype wire

// ===== design/ssla_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on ssla_pkg.
`default_nettype none
module ssla_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ssla_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output ssla_pkg::t_cmd      o_cmd,
    output ssla_pkg::t_q_stat   o_stat
);
    localparam int PW = (ssla_pkg::QUEUE_DEPTH > 1) ? $clog2(ssla_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(ssla_pkg::QUEUE_DEPTH + 1);

    ssla_pkg::t_cmd r_mem [ssla_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_stat.full  = (r_cnt == CW'(ssla_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_cmd        = r_mem[r_rd];

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(ssla_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(ssla_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

// ===== design/ssla_back.sv =====
// Back end: slot memory, accumulate and clear, and the evaluation sequencer
// with a shift-add squarer and a restoring divider. Depends on ssla_pkg, ssla_out_if.
`default_nettype none
module ssla_back #(
    parameter int MAX_SAMPLES = 16,
    localparam int UW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ssla_pkg::t_cmd                   i_cmd,
    input  ssla_pkg::t_q_stat                i_q_stat,
    output logic                             o_pop,
    input  logic [UW-1:0]                    i_slots,
    input  logic                             i_pooled,
    input  logic [ssla_pkg::PENALTY_W-1:0]   i_penalty,
    input  logic [ssla_pkg::BASE_W-1:0]      i_base,
    ssla_out_if.source                       o_out
);
    localparam int CW  = $clog2(MAX_SAMPLES);
    localparam int AW  = (CW > 0) ? CW : 1;
    localparam int NW  = ssla_pkg::COUNT_W + CW;
    localparam int MW  = ssla_pkg::SUM_W + CW;
    localparam int TSW = ssla_pkg::SUM_W + CW + 1;
    localparam int SQW = 2 * MW;
    localparam int LW  = ssla_pkg::SQ_W + CW;
    localparam int TW  = LW + 1;
    localparam int STW = $clog2(SQW + 1);
    localparam int VW  = ssla_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ACC, S_EV_RD, S_EV_DAT, S_SQ, S_DIV, S_ADD, S_FIN
    } t_state;

    t_state                         r_state;
    ssla_pkg::t_slot                r_mem [MAX_SAMPLES];
    logic [MAX_SAMPLES-1:0]         r_valid;
    ssla_pkg::t_slot                r_rd;
    logic                           r_rd_vld;
    logic [AW-1:0]                  r_addr;
    logic signed [VW-1:0]           r_value;
    logic [UW-1:0]                  r_cnt;
    logic [NW-1:0]                  r_tn;
    logic signed [TSW-1:0]          r_ts;
    logic [LW-1:0]                  r_tsq;
    logic [LW-1:0]                  r_loss;
    logic [LW-1:0]                  r_sub;
    logic [MW-1:0]                  r_s;
    logic [MW-1:0]                  r_mplr;
    logic [NW-1:0]                  r_n;
    logic [NW-1:0]                  r_rem;
    logic [SQW-1:0]                 r_dvd;
    logic [STW-1:0]                 r_step;
    logic                           r_out_valid;
    logic [ssla_pkg::OBJ_W-1:0]     r_obj;

    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;
    ssla_pkg::t_slot                wr_data;
    ssla_pkg::t_slot                slot_q;
    logic [VW:0]                    vmag_w;
    logic [VW-1:0]                  vmag;
    logic [2*VW-1:0]                vsq;
    logic [MW-1:0]                  slot_mag;
    logic [TSW-1:0]                 ts_neg;
    logic [MW-1:0]                  tot_mag;
    logic [SQW-1:0]                 sq_next;
    logic [NW:0]                    rem_sh;
    logic                           q_bit;
    logic [NW:0]                    rem_new;
    logic [LW-1:0]                  contrib;
    logic [TW-1:0]                  total;

    assign o_pop           = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_out.valid     = r_out_valid;
    assign o_out.objective = r_obj;

    // memory port control
    always_comb begin
        rd_en   = ((r_state == S_IDLE) && !i_q_stat.empty && (i_cmd.kind == ssla_pkg::CMD_ACC))
                  || ((r_state == S_EV_RD) && (r_cnt != i_slots));
        rd_addr = (r_state == S_IDLE) ? AW'(i_cmd.idx) : AW'(r_cnt);
    end

    // slot read data; a slot not written since clear reads as zero
    assign slot_q = r_rd_vld ? r_rd : '0;

    // accumulate one value into the slot read last cycle
    always_comb begin
        vmag_w = r_value[VW-1] ? ((VW+1)'(0) - (VW+1)'(r_value)) : (VW+1)'(r_value);
        vmag   = vmag_w[VW-1:0];
        vsq    = vmag * vmag;
        wr_en  = (r_state == S_ACC) && (slot_q.count != ssla_pkg::COUNT_MAX);
        wr_data.count = slot_q.count + ssla_pkg::COUNT_W'(1);
        wr_data.sum   = slot_q.sum + ssla_pkg::SUM_W'(r_value);
        wr_data.sumsq = slot_q.sumsq + ssla_pkg::SQ_W'(vsq);
    end

    // magnitudes of slot and pooled sums
    always_comb begin
        slot_mag = slot_q.sum[ssla_pkg::SUM_W-1] ? (MW'(0) - MW'(slot_q.sum)) : MW'(slot_q.sum);
        ts_neg   = TSW'(0) - TSW'(r_ts);
        tot_mag  = r_ts[TSW-1] ? ts_neg[MW-1:0] : r_ts[MW-1:0];
    end

    // squarer step, divider step, loss term and final sum
    always_comb begin
        sq_next = {r_dvd[SQW-2:0], 1'b0} + (r_mplr[MW-1] ? SQW'(r_s) : SQW'(0));
        rem_sh  = {r_rem, r_dvd[SQW-1]};
        q_bit   = (rem_sh >= {1'b0, r_n});
        rem_new = q_bit ? (rem_sh - {1'b0, r_n}) : rem_sh;
        contrib = r_sub - r_dvd[LW-1:0];
        total   = TW'(i_base) + TW'(i_penalty) + TW'(r_loss);
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // sequencer, valid bits and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken result unless a new one replaces it this cycle
            if (r_out_valid && o_out.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            if (rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        unique case (i_cmd.kind)
                            ssla_pkg::CMD_ACC: begin
                                r_addr  <= AW'(i_cmd.idx);
                                r_value <= i_cmd.value;
                                r_state <= S_ACC;
                            end
                            ssla_pkg::CMD_CLR: begin
                                r_valid <= '0;
                            end
                            ssla_pkg::CMD_EVAL: begin
                                r_cnt   <= '0;
                                r_tn    <= '0;
                                r_ts    <= '0;
                                r_tsq   <= '0;
                                r_loss  <= '0;
                                r_state <= S_EV_RD;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ACC: begin
                    if (wr_en) begin
                        r_valid[r_addr] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_EV_RD: begin
                    if (r_cnt == i_slots) begin
                        if (i_pooled && (r_tn != '0)) begin
                            r_s     <= tot_mag;
                            r_mplr  <= tot_mag;
                            r_n     <= r_tn;
                            r_sub   <= r_tsq;
                            r_dvd   <= '0;
                            r_step  <= '0;
                            r_state <= S_SQ;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_EV_DAT;
                    end
                end
                S_EV_DAT: begin
                    if (i_pooled) begin
                        r_tn    <= r_tn + NW'(slot_q.count);
                        r_ts    <= r_ts + TSW'(slot_q.sum);
                        r_tsq   <= r_tsq + LW'(slot_q.sumsq);
                        r_state <= S_EV_RD;
                    end else if (slot_q.count != '0) begin
                        r_s     <= slot_mag;
                        r_mplr  <= slot_mag;
                        r_n     <= NW'(slot_q.count);
                        r_sub   <= LW'(slot_q.sumsq);
                        r_dvd   <= '0;
                        r_step  <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_state <= S_EV_RD;
                    end
                end
                S_SQ: begin
                    // one multiplier bit per cycle, MSB first
                    r_dvd  <= sq_next;
                    r_mplr <= {r_mplr[MW-2:0], 1'b0};
                    if (r_step == STW'(MW - 1)) begin
                        r_step  <= '0;
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle; quotient replaces the dividend
                    r_rem <= rem_new[NW-1:0];
                    r_dvd <= {r_dvd[SQW-2:0], q_bit};
                    if (r_step == STW'(SQW - 1)) begin
                        r_state <= S_ADD;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_ADD: begin
                    r_loss  <= r_loss + contrib;
                    r_state <= i_pooled ? S_FIN : S_EV_RD;
                end
                S_FIN: begin
                    // hold until the result register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_obj       <= (total > TW'(ssla_pkg::OBJ_MAX)) ? ssla_pkg::OBJ_MAX
                                                                        : total[ssla_pkg::OBJ_W-1:0];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/segment_squared_loss_accumulator.sv =====
// Accumulate: slot read, then write in S_ACC; clear: done in S_IDLE; a word can enter
// every cycle while the 2-entry queue has room. Evaluate: S_EV_RD and S_EV_DAT per slot;
// per squared term MW shift-add square steps and 2*MW restoring divide steps
// (MW = 32 + ceil(log2(MAX_SAMPLES))). Result sits in an output register.
// Reset (synchronous, active low) empties the queue, clears all slots via their valid
// bits at once, resets sequencer, result valid and config registers; no clearing pass.
`default_nettype none
`include "segment_squared_loss_accumulator_defines.svh"
module segment_squared_loss_accumulator #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ssla_in_if.sink                            i_in_ch,
    ssla_out_if.source                         o_out_ch,
    input  logic                               i_cfg_we,
    input  logic [ssla_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ssla_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int UW = $clog2(MAX_SAMPLES + 1);

    logic [ssla_pkg::SAMPLES_W-1:0]  r_samples;
    logic                            r_pooled;
    logic [ssla_pkg::PENALTY_W-1:0]  r_penalty;
    logic [ssla_pkg::BASE_W-1:0]     r_base;
    logic [UW-1:0]                   slots;
    logic                            push;
    logic                            pop;
    ssla_pkg::t_cmd                  front_cmd;
    ssla_pkg::t_cmd                  head_cmd;
    ssla_pkg::t_q_stat               q_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples <= ssla_pkg::SAMPLES_W'(16);
            r_pooled  <= 1'b0;
            r_penalty <= '0;
            r_base    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssla_pkg::CFG_SAMPLES: r_samples <= i_cfg_data[ssla_pkg::SAMPLES_W-1:0];
                ssla_pkg::CFG_POOLED:  r_pooled  <= i_cfg_data[0];
                ssla_pkg::CFG_PENALTY: r_penalty <= i_cfg_data[ssla_pkg::PENALTY_W-1:0];
                ssla_pkg::CFG_BASE:    r_base    <= i_cfg_data[ssla_pkg::BASE_W-1:0];
                default: r_pooled <= r_pooled;
            endcase
        end
    end

    // clamp slot count to the memory depth
    always_comb begin
        if (32'(r_samples) > MAX_SAMPLES) begin
            slots = UW'(MAX_SAMPLES);
        end else begin
            slots = UW'(r_samples);
        end
    end

    ssla_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_in     (i_in_ch),
        .i_slots  (slots),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    ssla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    ssla_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .i_slots   (slots),
        .i_pooled  (r_pooled),
        .i_penalty (r_penalty),
        .i_base    (r_base),
        .o_out     (o_out_ch)
    );

    `SSLA_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, push, !q_stat.full)
    `SSLA_ASSERT_IMPLY(a_pop_data, i_clk, i_rst_n, pop, !q_stat.empty)
    `SSLA_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, push && !pop, !q_stat.empty)
endmodule
`default_nettype wire

// ===== tb/ssla_tb_if.sv =====
// Testbench-side copies of the accumulator channel interfaces are not needed;
// this file holds the stimulus word type used by the testbench top.
// Depends on ssla_pkg.
package ssla_tb_pkg;
    import ssla_pkg::*;

    // one input word as the testbench stores it
    typedef struct {
        logic [OP_W-1:0]           op;
        logic [IDX_W-1:0]          sample_index;
        logic signed [VALUE_W-1:0] value;
        logic                      is_missing;
        bit                        has_objective;
        logic [OBJ_W-1:0]          objective;
    } t_stim_word;
endpackage

// ===== tb/testbench.sv =====
// Testbench of segment_squared_loss_accumulator: directed table and cases, then
// random words in idle and stall phases, checked against a slot-sum predictor.
// Depends on ssla_pkg, ssla_tb_pkg, ssla_in_if and ssla_out_if.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ssla_pkg::*;
    import ssla_tb_pkg::*;

    localparam int SLOTS = 16;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ssla_in_if  in_ch ();
    ssla_out_if out_ch ();

    segment_squared_loss_accumulator #(.MAX_SAMPLES(SLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ch(in_ch.sink), .o_out_ch(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [SAMPLES_W-1:0] p_samples;
    logic                 p_pooled;
    logic [PENALTY_W-1:0] p_penalty;
    logic [BASE_W-1:0]    p_base;
    logic [COUNT_W-1:0]   p_count [SLOTS];
    longint               p_sum [SLOTS];
    logic [SQ_W-1:0]      p_sumsq [SLOTS];

    logic [OBJ_W-1:0] objective_q[$];
    int  mismatches;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // floor(s*s/n) without losing bits
    function automatic logic [127:0] square_over(longint unsigned s, longint unsigned n);
        logic [127:0] sq;
        sq = 128'(s) * 128'(s);
        return sq / 128'(n);
    endfunction

    function automatic longint unsigned magnitude(longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    function automatic int slots_active();
        return p_samples > SLOTS ? SLOTS : int'(p_samples);
    endfunction

    function automatic logic [OBJ_W-1:0] predict_objective();
        logic [127:0] loss;
        logic [127:0] total;
        longint unsigned tn;
        longint ts;
        logic [127:0] tsq;
        loss = 0;
        tn = 0;
        ts = 0;
        tsq = 0;
        if (p_pooled) begin
            for (int i = 0; i < slots_active(); i++) begin
                tn += p_count[i];
                ts += p_sum[i];
                tsq += p_sumsq[i];
            end
            if (tn > 0) loss = tsq - square_over(magnitude(ts), tn);
        end else begin
            for (int i = 0; i < slots_active(); i++) begin
                if (p_count[i] != 0)
                    loss += p_sumsq[i] - square_over(magnitude(p_sum[i]), p_count[i]);
            end
        end
        total = loss + p_base + p_penalty;
        return total > OBJ_MAX ? OBJ_MAX : total[OBJ_W-1:0];
    endfunction

    // advance the slot state for one accepted word; return 1 if it yields an objective
    function automatic bit apply_word(t_stim_word w, output logic [OBJ_W-1:0] obj);
        int unsigned mag;
        obj = '0;
        case (w.op)
            OP_ACC: begin
                if (!w.is_missing && w.sample_index < slots_active()
                        && p_count[w.sample_index] != COUNT_MAX) begin
                    mag = 32'(magnitude(longint'(w.value)));
                    p_count[w.sample_index] += COUNT_W'(1);
                    p_sum[w.sample_index] += longint'(w.value);
                    p_sumsq[w.sample_index] += SQ_W'(mag) * SQ_W'(mag);
                end
            end
            OP_CLR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    p_count[i] = 0;
                    p_sum[i] = 0;
                    p_sumsq[i] = 0;
                end
            end
            OP_EVAL: begin
                obj = predict_objective();
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SAMPLES: p_samples = data[SAMPLES_W-1:0];
            CFG_POOLED:  p_pooled = data[0];
            CFG_PENALTY: p_penalty = data[PENALTY_W-1:0];
            CFG_BASE:    p_base = data[BASE_W-1:0];
            default: ;
        endcase
    endtask

    // offer one word and hold it until accepted; valid stays up for the next word
    task automatic send_word(t_stim_word w);
        logic [OBJ_W-1:0] obj;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= w.op;
        in_ch.sample_index <= w.sample_index;
        in_ch.value <= w.value;
        in_ch.is_missing <= w.is_missing;
        do @(posedge i_clk); while (!in_ch.ready);
        if (apply_word(w, obj)) objective_q.push_back(w.has_objective ? w.objective : obj);
        @(negedge i_clk);
    endtask

    // drop valid, wait until every objective has come, then let the back end go idle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (objective_q.size() != 0) @(negedge i_clk);
        repeat (2000) @(negedge i_clk);
    endtask

    function automatic t_stim_word rand_word(bit well_formed);
        t_stim_word w;
        int r;
        r = $urandom_range(99);
        w.op = r < 85 ? OP_ACC : (r < 92 ? OP_EVAL : (r < 96 ? OP_CLR : OP_NONE));
        if (!well_formed) w.op = 2'($urandom);
        w.sample_index = 4'($urandom);
        w.value = $urandom_range(3) == 0 ? (($urandom & 1) ? 16'sh7FFF : 16'sh8000)
                                         : 16'($urandom);
        w.is_missing = $urandom_range(9) == 0;
        w.has_objective = 0;
        w.objective = '0;
        return w;
    endfunction

    function automatic t_stim_word mk(logic [OP_W-1:0] op, int idx, int val, bit miss,
                                      bit known = 0, logic [OBJ_W-1:0] obj = '0);
        t_stim_word w;
        w.op = op;
        w.sample_index = 4'(idx);
        w.value = 16'(val);
        w.is_missing = miss;
        w.has_objective = known;
        w.objective = obj;
        return w;
    endfunction

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (objective_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected objective %0h", out_ch.objective);
            end else begin
                if (out_ch.objective !== objective_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("objective mismatch: expected %0h actual %0h",
                                 objective_q[0], out_ch.objective);
                end
                void'(objective_q.pop_front());
            end
        end
    end

    // receiver stalls
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= !hold_off &&
                            !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("** segment_squared_loss_accumulator: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        t_stim_word table_words[$];
        int phase_idle [4] = '{0, 62, 0, 29};
        int phase_stall [4] = '{0, 0, 62, 29};
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_ACC;
        in_ch.sample_index = '0;
        in_ch.value = '0;
        in_ch.is_missing = 1'b0;
        p_samples = 16;
        p_pooled = 0;
        p_penalty = 0;
        p_base = 0;
        for (int i = 0; i < SLOTS; i++) begin
            p_count[i] = 0;
            p_sum[i] = 0;
            p_sumsq[i] = 0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table: known results after reset and clear, predicted rows otherwise
        table_words.push_back(mk(OP_EVAL, 0, 0, 0, 1, '0));
        table_words.push_back(mk(OP_ACC, 0, 'h7FFF, 0));
        table_words.push_back(mk(OP_ACC, 0, 'h8000, 0));
        table_words.push_back(mk(OP_ACC, 15, 'h0100, 0));
        table_words.push_back(mk(OP_ACC, 15, 'h0300, 0));
        table_words.push_back(mk(OP_ACC, 3, 'h1234, 1));
        table_words.push_back(mk(OP_NONE, 5, 'h1111, 0));
        table_words.push_back(mk(OP_EVAL, 0, 0, 0));
        table_words.push_back(mk(OP_CLR, 0, 0, 0));
        table_words.push_back(mk(OP_EVAL, 0, 0, 0, 1, '0));
        table_words.push_back(mk(OP_ACC, 7, -1, 0));
        table_words.push_back(mk(OP_ACC, 7, 1, 0));
        table_words.push_back(mk(OP_EVAL, 0, 0, 0));
        foreach (table_words[i]) send_word(table_words[i]);
        drain();

        // out-of-range slots, slot count zero and above the maximum, pooled mode
        write_reg(CFG_SAMPLES, CFG_DATA_W'(2));
        write_reg(CFG_POOLED, CFG_DATA_W'(1));
        send_word(mk(OP_ACC, 1, 'h0200, 0));
        send_word(mk(OP_ACC, 2, 'h0400, 0));
        send_word(mk(OP_EVAL, 0, 0, 0));
        drain();
        write_reg(CFG_SAMPLES, CFG_DATA_W'(0));
        send_word(mk(OP_EVAL, 0, 0, 0, 1, '0));
        drain();
        write_reg(CFG_SAMPLES, CFG_DATA_W'(31));
        write_reg(CFG_PENALTY, CFG_DATA_W'(31'h7FFFFFFF));
        write_reg(CFG_BASE, CFG_DATA_W'(47'h7FFFFFFFFFFF));
        send_word(mk(OP_EVAL, 0, 0, 0));
        drain();

        // extreme values into one slot, back to back
        write_reg(CFG_PENALTY, CFG_DATA_W'(0));
        write_reg(CFG_BASE, CFG_DATA_W'(0));
        write_reg(CFG_POOLED, CFG_DATA_W'(0));
        send_word(mk(OP_CLR, 0, 0, 0));
        for (int i = 0; i < 16; i++) send_word(mk(OP_ACC, 0, (i & 1) ? 'h8000 : 'h7FFF, 0));
        send_word(mk(OP_EVAL, 0, 0, 0));
        drain();

        // long receiver hold-off while words keep coming
        send_word(mk(OP_CLR, 0, 0, 0));
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++) send_word(mk(OP_EVAL, 0, 0, 0));
        join
        drain();

        // random phases with differing settings
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = phase_idle[ph % 4];
            recv_stall_pct = phase_stall[ph % 4];
            write_reg(CFG_SAMPLES, CFG_DATA_W'(ph == 7 ? 1 : $urandom_range(17)));
            write_reg(CFG_POOLED, CFG_DATA_W'(ph & 1));
            write_reg(CFG_PENALTY, ph == 5 ? CFG_DATA_W'(31'h7FFFFFFF)
                                           : CFG_DATA_W'($urandom_range(65535 * 16)));
            write_reg(CFG_BASE, ph == 5 ? CFG_DATA_W'(47'h7FFFFFFFFFFF)
                                        : CFG_DATA_W'($urandom));
            for (int i = 0; i < 190; i++) send_word(rand_word($urandom_range(9) != 0));
            send_word(mk(OP_EVAL, 0, 0, 0));
            drain();
        end
        send_idle_pct = 0;
        in_ch.valid <= 1'b0;

        if (mismatches == 0 && objective_q.size() == 0) begin
            $display("** segment_squared_loss_accumulator: PASSED **");
        end else begin
            $display("** segment_squared_loss_accumulator: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/ssla_pkg.sv
design/ssla_in_if.sv
design/ssla_out_if.sv
design/ssla_front.sv
design/ssla_queue.sv
design/ssla_back.sv
design/segment_squared_loss_accumulator.sv
tb/ssla_tb_if.sv
tb/testbench.sv
